/* src/max_priority_queue_with_fifo_pop_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the priority queue block
// Clocked, reset-qualified implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_WITH_FIFO_POP_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_WITH_FIFO_POP_ASSERT_SVH

// same-cycle implication
`define MPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the priority queue block.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int VAL_W = 8;
    localparam int PRI_W = 8;
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        KIND_PUSH       = 2'd0,
        KIND_POP_OLDEST = 2'd1,
        KIND_POP_MAX    = 2'd2,
        KIND_PEEK_MAX   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the incoming operation
        logic scan;    // compare one entry against the running max
        logic commit;  // apply update, load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic needs_scan;  // incoming op is a max op on a non-empty queue
        logic scan_last;   // scan is at the oldest entry
        logic out_free;    // output register can take a result this cycle
    } t_dp_stat;

endpackage

/* src/max_priority_queue_with_fifo_pop.sv */
// ----------------------------------------------------------------------------
// max_priority_queue_with_fifo_pop
// Bounded queue of (value, priority) entries with FIFO pop and max pop/peek.
// ----------------------------------------------------------------------------
// Input beats carry one operation: tuser = kind (push, pop oldest, pop max,
// peek max), tdata = value and priority. Every input beat yields exactly one
// output beat with result value, status (ok, empty, full) and occupancy.
// Push and pop-oldest go from accept straight to the commit state. Pop-max
// and peek-max on a non-empty queue first run a max search that walks the
// entries one per cycle, newest to oldest, through a single compare unit.
// One operation is in flight at a time; s_axis_tready is high only while
// the sequencer is idle, so a new beat is taken only after the previous
// operation has committed its result.
// Results sit in an output register; a stalled receiver holds the finished
// beat there while the next operation is accepted and worked on; its commit
// then waits until the register frees up.
// Reset empties the queue and drops any pending result; entry contents are
// not cleared, as only occupied entries are ever read.
// ----------------------------------------------------------------------------
module max_priority_queue_with_fifo_pop #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] value, [15:8] priority_req
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] result_value, [9:8] status,
                                        // [14:10] occupancy, [15] zero
);
    import mpq_pkg::*;

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [VAL_W-1:0] res_val;
    t_status          res_st;
    logic [OCC_W-1:0] res_occ;

    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (t_kind'(s_axis_tuser)),
        .i_value        (s_axis_tdata[7:0]),
        .i_priority_req (s_axis_tdata[15:8]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_result_value (res_val),
        .o_status       (res_st),
        .o_occupancy    (res_occ)
    );

    assign m_axis_tdata = {1'b0, res_occ, res_st, res_val};

endmodule

/* src/mpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer: accept an operation, run the max scan if needed, then commit.
// ----------------------------------------------------------------------------
module mpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mpq_pkg::t_dp_stat i_stat,
    output mpq_pkg::t_dp_cmd  o_cmd
);
    import mpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.needs_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/mpq_datapath.sv */
// ----------------------------------------------------------------------------
// mpq_datapath
// Entry cells in arrival order, serial max scan and the output register.
// ----------------------------------------------------------------------------
module mpq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mpq_pkg::t_dp_cmd          i_cmd,
    output mpq_pkg::t_dp_stat         o_stat,
    input  mpq_pkg::t_kind            i_kind,
    input  logic [mpq_pkg::VAL_W-1:0] i_value,
    input  logic [mpq_pkg::PRI_W-1:0] i_priority_req,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [mpq_pkg::VAL_W-1:0] o_result_value,
    output mpq_pkg::t_status          o_status,
    output logic [mpq_pkg::OCC_W-1:0] o_occupancy
);
    import mpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [VAL_W-1:0] r_val [QUEUE_DEPTH];
    logic [PRI_W-1:0] r_pri [QUEUE_DEPTH];
    logic [CW-1:0]    r_count;

    t_kind            r_kind;
    logic [VAL_W-1:0] r_value;
    logic [PRI_W-1:0] r_prio;

    logic [IW-1:0]    r_idx;
    logic             r_best_vld;
    logic [PRI_W-1:0] r_best_pri;
    logic [VAL_W-1:0] r_best_val;
    logic [IW-1:0]    r_best_pos;

    logic             r_out_vld;
    logic [VAL_W-1:0] r_res_val;
    t_status          r_res_st;
    logic [OCC_W-1:0] r_res_occ;

    logic [CW-1:0]       cnt_m1;
    logic [PRI_W-1:0]    scan_pri;
    logic                scan_take;
    logic                do_push;
    logic                do_remove;
    logic [IW-1:0]       rm_pos;
    logic [VAL_W-1:0]    res_val;
    t_status             res_st;
    logic [CW-1:0]       n_count;
    logic [CW+OCC_W-1:0] occ_ext;

    assign cnt_m1    = r_count - CW'(1);
    assign scan_pri  = r_pri[r_idx];
    // newest first, strict compare: ties keep the newer entry
    assign scan_take = !r_best_vld || (scan_pri > r_best_pri);

    assign o_stat.needs_scan = ((i_kind == KIND_POP_MAX) || (i_kind == KIND_PEEK_MAX))
                               && (r_count != '0);
    assign o_stat.scan_last  = (r_idx == '0);
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    always_comb begin
        do_push   = 1'b0;
        do_remove = 1'b0;
        rm_pos    = '0;
        res_val   = '0;
        res_st    = ST_OK;
        n_count   = r_count;
        case (r_kind)
            KIND_PUSH: begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    res_st = ST_FULL;
                end else begin
                    do_push = 1'b1;
                    n_count = r_count + CW'(1);
                    res_val = r_value;
                end
            end
            KIND_POP_OLDEST: begin
                if (r_count == '0) begin
                    res_st = ST_EMPTY;
                end else begin
                    res_val   = r_val[0];
                    do_remove = 1'b1;
                    n_count   = cnt_m1;
                end
            end
            KIND_POP_MAX: begin
                if (r_count == '0) begin
                    res_st = ST_EMPTY;
                end else begin
                    res_val   = r_best_val;
                    rm_pos    = r_best_pos;
                    do_remove = 1'b1;
                    n_count   = cnt_m1;
                end
            end
            KIND_PEEK_MAX: begin
                if (r_count == '0) begin
                    res_st = ST_EMPTY;
                end else begin
                    res_val = r_best_val;
                end
            end
            default: begin
                res_st = ST_OK;
            end
        endcase
    end

    assign occ_ext = {{OCC_W{1'b0}}, n_count};

    // entry cells: push writes at the tail, removal shifts the upper part down
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g < QUEUE_DEPTH - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_cmd.commit) begin
                    if (do_push && (r_count[IW-1:0] == IW'(g))) begin
                        r_val[g] <= r_value;
                        r_pri[g] <= r_prio;
                    end else if (do_remove && (IW'(g) >= rm_pos)) begin
                        r_val[g] <= r_val[g+1];
                        r_pri[g] <= r_pri[g+1];
                    end
                end
            end
        end else begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_cmd.commit && do_push && (r_count[IW-1:0] == IW'(g))) begin
                    r_val[g] <= r_value;
                    r_pri[g] <= r_prio;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_value    <= i_value;
            r_prio     <= i_priority_req;
            r_idx      <= cnt_m1[IW-1:0];
            r_best_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            if (scan_take) begin
                r_best_pri <= scan_pri;
                r_best_val <= r_val[r_idx];
                r_best_pos <= r_idx;
            end
            r_best_vld <= 1'b1;
            r_idx      <= r_idx - IW'(1);
        end
        if (i_cmd.commit) begin
            r_res_val <= res_val;
            r_res_st  <= res_st;
            r_res_occ <= occ_ext[OCC_W-1:0];
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_res_val;
    assign o_status       = r_res_st;
    assign o_occupancy    = r_res_occ;

endmodule

/* src/mpq_checker.sv */
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "max_priority_queue_with_fifo_pop_assert.svh"

module mpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import mpq_pkg::*;

    logic in_beat;
    logic out_stall;
    logic res_empty;
    logic res_full;
    logic val_zero;
    logic occ_zero;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign res_empty = m_axis_tvalid && (m_axis_tdata[9:8] == ST_EMPTY);
    assign res_full  = m_axis_tvalid && (m_axis_tdata[9:8] == ST_FULL);
    assign val_zero  = (m_axis_tdata[7:0] == '0);
    assign occ_zero  = (m_axis_tdata[14:10] == '0);

    // one op at a time: no accept in the cycle after an accept
    `MPQ_ASSERT_NEXT(a_single_op, i_clk, i_rst_n, in_beat, !s_axis_tready, "back-to-back accept")

    `MPQ_ASSERT_NOW(a_empty_res, i_clk, i_rst_n, res_empty, val_zero && occ_zero, "empty not zero")

    `MPQ_ASSERT_NOW(a_full_res, i_clk, i_rst_n, res_full, val_zero, "dropped push returned data")

    `MPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

endmodule

bind max_priority_queue_with_fifo_pop mpq_checker u_mpq_checker (.*);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb - priority queue with oldest-first pop
// Drives push, pop-oldest, pop-max and peek-max operations over the input
// stream and checks each output beat against a behavioral copy of the queue
// (arrival-ordered entries, newest wins on priority ties). Both stream sides
// idle at random; the queue is pushed through empty and full many times.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int N_RANDOM    = 400;

    typedef struct packed {
        logic [VAL_W-1:0] rval;
        t_status          status;
        logic [OCC_W-1:0] occ;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] value, [15:8] priority_req
    logic [1:0]  s_axis_tuser;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] result_value, [9:8] status,
                                 // [14:10] occupancy, [15] zero

    // shadow copy of the queue, index 0 = oldest
    logic [VAL_W-1:0] held_vals[$];
    logic [PRI_W-1:0] held_pris[$];
    t_result          pending_results[$];

    int  mismatches  = 0;
    int  n_results   = 0;
    int  kind_count[4];
    int  full_hits   = 0;
    int  empty_hits  = 0;
    int  peak_occ    = 0;
    bit  tx_gaps_on  = 1'b1;
    bit  rx_gaps_on  = 1'b1;
    int  rx_stall    = 0;

    always #6 i_clk = ~i_clk;

    max_priority_queue_with_fifo_pop #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic t_result apply_op(t_kind k, logic [VAL_W-1:0] v,
                                         logic [PRI_W-1:0] p);
        t_result r;
        int      best;
        r.rval   = '0;
        r.status = ST_OK;
        kind_count[k]++;
        if (k == KIND_PUSH) begin
            if (held_vals.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
                full_hits++;
            end else begin
                held_vals.push_back(v);
                held_pris.push_back(p);
                r.rval = v;
            end
        end else if (held_vals.size() == 0) begin
            r.status = ST_EMPTY;
            empty_hits++;
        end else if (k == KIND_POP_OLDEST) begin
            r.rval = held_vals.pop_front();
            void'(held_pris.pop_front());
        end else begin
            // scan newest to oldest, strictly greater replaces: newest wins ties
            best = held_vals.size() - 1;
            for (int i = best - 1; i >= 0; i--) begin
                if (held_pris[i] > held_pris[best]) best = i;
            end
            r.rval = held_vals[best];
            if (k == KIND_POP_MAX) begin
                held_vals.delete(best);
                held_pris.delete(best);
            end
        end
        r.occ = OCC_W'(held_vals.size());
        if (held_vals.size() > peak_occ) peak_occ = held_vals.size();
        return r;
    endfunction

    task automatic send_op(t_kind k, logic [VAL_W-1:0] v, logic [PRI_W-1:0] p);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {p, v};
        s_axis_tuser  <= k;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_op(k, v, p));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver side: random stalls on tready
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (rx_gaps_on && $urandom_range(0, 99) < 25) begin
            rx_stall = pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.rval ||
                    m_axis_tdata[9:8] !== want.status ||
                    m_axis_tdata[14:10] !== want.occ) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp val=%h st=%0d occ=%0d, got val=%h st=%0d occ=%0d",
                                 n_results, want.rval, want.status, want.occ,
                                 m_axis_tdata[7:0], m_axis_tdata[9:8],
                                 m_axis_tdata[14:10]);
                end
            end
        end
    end

    // pops and peeks on an empty queue, then a single entry pushed and taken out, twice
    task automatic test_empty_queue();
        send_op(KIND_POP_OLDEST, 8'hA5, 8'h5A);
        send_op(KIND_POP_MAX,    8'hFF, 8'hFF);
        send_op(KIND_PEEK_MAX,   8'h3C, 8'h00);
        send_op(KIND_PUSH,       8'hFF, 8'hFF);
        send_op(KIND_POP_MAX,    8'h00, 8'h00);
        send_op(KIND_PUSH,       8'h00, 8'h00);
        send_op(KIND_POP_OLDEST, 8'hFF, 8'hFF);
    endtask

    // fill to the top with tied maxima, overflow once, then serve the max
    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_op(KIND_PUSH, 8'(8'h10 + i),
                    (i % 5 == 2) ? 8'hFF : 8'(i * 3));
        end
        send_op(KIND_PUSH, 8'hEE, 8'hFF);
        send_op(KIND_PEEK_MAX, 8'h00, 8'h00);
        send_op(KIND_POP_MAX,  8'h00, 8'h00);
        // sender holds off until the queue has answered everything
        wait_results_drained();
    endtask

    task automatic test_random_mix();
        int          sent;
        int          seg_len;
        int          push_pct;
        int          pri_mode;
        t_kind       k;
        logic [7:0]  v;
        logic [7:0]  p;
        sent = 0;
        while (sent < N_RANDOM) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 20;
            endcase
            pri_mode   = $urandom_range(0, 2);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < seg_len && sent < N_RANDOM; i++) begin
                if ($urandom_range(0, 99) < push_pct) k = KIND_PUSH;
                else k = t_kind'($urandom_range(1, 3));
                v = 8'($urandom_range(0, 255));
                case (pri_mode)
                    0: p = 8'($urandom_range(0, 3));   // lots of ties
                    1: p = 8'($urandom_range(0, 255));
                    default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                send_op(k, v, p);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_results_drained();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        int guard;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PUSH;
        m_axis_tready = 1'b0;
        foreach (kind_count[i]) kind_count[i] = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_full_queue();
        test_random_mix();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2 * QUEUE_DEPTH + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d results never arrived", pending_results.size());
        end

        $display("Covered %0d pushes, %0d oldest pops, %0d max pops, %0d peeks",
                 kind_count[KIND_PUSH], kind_count[KIND_POP_OLDEST],
                 kind_count[KIND_POP_MAX], kind_count[KIND_PEEK_MAX]);
        $display("%0d full drops, %0d empty hits, peak occupancy %0d, %0d mismatches",
                 full_hits, empty_hits, peak_occ, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("ERROR: timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule
